[rtl/histogram_colormap_downsampler_defines.svh]
// assertion macros used by the downsampler top level
`ifndef HISTOGRAM_COLORMAP_DOWNSAMPLER_DEFINES_SVH
`define HISTOGRAM_COLORMAP_DOWNSAMPLER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hcd_pkg.sv]
// types, codes and the reciprocal table of the colormap downsampler
package hcd_pkg;

  // widest column and table address any parameter setting needs
  localparam int PX_MAX_W    = 13;
  localparam int TADDR_MAX_W = 16;

  // shift that goes with the reciprocal table
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;

  // input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_COUNT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_OVERSAMPLE  = 2'd0;
  localparam logic [1:0] REG_PIXEL_WIDTH = 2'd1;
  localparam logic [1:0] REG_TABLE_TOP   = 2'd2;

  typedef enum logic {
    OP_LOAD,
    OP_CELL
  } hcd_op_t;

  typedef struct packed {
    logic        command;
    logic [11:0] table_index;
    logic [31:0] table_color;
    logic [31:0] count;
  } hcd_in_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic [9:0]  pixel_column;
    logic        row_end;
  } hcd_out_t;

  // classified work item between front and back
  typedef struct packed {
    hcd_op_t                op;
    logic [TADDR_MAX_W-1:0] addr;
    logic [31:0]            color;
    logic [PX_MAX_W-1:0]    px;
    logic                   first;
    logic                   emit;
    logic                   row_end;
  } hcd_work_t;

  // ceil(2^RECIP_SHIFT / (os*os)); exact for lane sums below 2^14
  function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] os);
    logic [RECIP_W-1:0] r;
    case (os)
      3'd2:    r = 21'd262144;
      3'd3:    r = 21'd116509;
      3'd4:    r = 21'd65536;
      3'd5:    r = 21'd41944;
      3'd6:    r = 21'd29128;
      3'd7:    r = 21'd21400;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

[rtl/hcd_queue.sv]
// small first-in first-out queue with fill count
module hcd_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  T                             push_data,
  output logic                         full,
  input  logic                         pop,
  output T                             pop_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  T                 slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = slots_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/hcd_front.sv]
// front end: takes input items, tracks the raster position, classifies work
module hcd_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  hcd_pkg::hcd_in_t              in_data,
  output logic                          in_full,
  input  logic                          restart,
  input  logic [2:0]                    os_eff,
  input  logic [hcd_pkg::PX_MAX_W-1:0]  wlast,
  input  logic [11:0]                   table_top,
  output logic                          work_push,
  output hcd_pkg::hcd_work_t            work_data,
  input  logic                          work_full
);
  import hcd_pkg::*;

  localparam int PX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [PX_W-1:0] px_r, px_nxt;
  logic [2:0]      sx_r, sx_nxt;
  logic [2:0]      srow_r, srow_nxt;
  logic [2:0]      os_last;
  logic            px_last, sx_last, row_last;
  logic            accept, is_cell, load_ok;
  logic [31:0]     lim, sel;

  assign in_full = work_full;
  assign accept  = in_push && !work_full;
  assign is_cell = (in_data.command == CMD_COUNT);
  assign load_ok = (32'(in_data.table_index) < 32'(TABLE_DEPTH));

  // position flags of the current cell
  assign os_last  = os_eff - 3'd1;
  assign px_last  = (px_r == wlast[PX_W-1:0]);
  assign sx_last  = (sx_r == os_last);
  assign row_last = (srow_r == os_last);

  // clamped colour lookup index
  always_comb begin
    lim = (32'(table_top) > 32'(TABLE_DEPTH - 1)) ? 32'(TABLE_DEPTH - 1) : 32'(table_top);
    sel = (in_data.count < lim) ? in_data.count : lim;
  end

  // work item build
  always_comb begin
    work_push         = accept && (is_cell || load_ok);
    work_data.op      = is_cell ? OP_CELL : OP_LOAD;
    work_data.addr    = is_cell ? TADDR_MAX_W'(sel) : TADDR_MAX_W'(in_data.table_index);
    work_data.color   = in_data.table_color;
    work_data.px      = PX_MAX_W'(px_r);
    work_data.first   = (srow_r == 3'd0) && (sx_r == 3'd0);
    work_data.emit    = row_last && sx_last;
    work_data.row_end = px_last;
  end

  // raster position advance
  always_comb begin
    px_nxt   = px_r;
    sx_nxt   = sx_r;
    srow_nxt = srow_r;
    if (restart) begin
      px_nxt   = '0;
      sx_nxt   = '0;
      srow_nxt = '0;
    end else if (accept && is_cell) begin
      if (!sx_last) begin
        sx_nxt = sx_r + 3'd1;
      end else begin
        sx_nxt = '0;
        if (!px_last) begin
          px_nxt = px_r + PX_W'(1);
        end else begin
          px_nxt   = '0;
          srow_nxt = row_last ? 3'd0 : srow_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r   <= '0;
      sx_r   <= '0;
      srow_r <= '0;
    end else begin
      px_r   <= px_nxt;
      sx_r   <= sx_nxt;
      srow_r <= srow_nxt;
    end
  end

endmodule

[rtl/hcd_back.sv]
// back end: colour table, per-column lane sums, block average, result queue
module hcd_back #(
  parameter int MAX_WIDTH      = 1024,
  parameter int TABLE_DEPTH    = 4096,
  parameter int MAX_OVERSAMPLE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               work_empty,
  input  hcd_pkg::hcd_work_t work_data,
  output logic               work_pop,
  input  logic [2:0]         os_eff,
  input  logic               out_pop,
  output hcd_pkg::hcd_out_t  out_data,
  output logic               out_empty
);
  import hcd_pkg::*;

  localparam int PX_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int TBL_W     = $clog2(TABLE_DEPTH);
  localparam int SUM_W     = $clog2(MAX_OVERSAMPLE * MAX_OVERSAMPLE * 255 + 1);
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int OUT_DEPTH = 4;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef logic [3:0][SUM_W-1:0] sums_t;

  logic [31:0]      color_mem [TABLE_DEPTH];
  sums_t            lane_mem  [MAX_WIDTH];

  logic [TBL_W-1:0] head_taddr;
  logic [PX_W-1:0]  head_px;
  logic [31:0]      color_q_r;
  sums_t            lane_q_r;

  logic             b_valid_r;
  logic [PX_W-1:0]  b_px_r;
  logic             b_first_r, b_emit_r, b_row_end_r;
  sums_t            b_old, b_new;

  logic             fwd_valid_r;
  logic [PX_W-1:0]  fwd_px_r;
  sums_t            fwd_sums_r;

  logic             c_valid_r;
  sums_t            c_sums_r;
  logic [PX_W-1:0]  c_px_r;
  logic             c_row_end_r;
  logic [PROD_W-1:0] prod [4];
  logic [RECIP_W-1:0] recip;
  hcd_out_t         res;

  logic [OCNT_W-1:0] out_count;

  assign head_taddr = work_data.addr[TBL_W-1:0];
  assign head_px    = work_data.px[PX_W-1:0];

  // take work only when the result queue has room for everything in flight
  assign work_pop = !work_empty &&
                    ((32'(out_count) + 32'(b_valid_r) + 32'(c_valid_r)) < OUT_DEPTH);

  // colour table: load writes, registered lookup
  always_ff @(posedge clk) begin
    if (work_pop && work_data.op == OP_LOAD) begin
      color_mem[head_taddr] <= work_data.color;
    end
    color_q_r <= color_mem[head_taddr];
  end

  // lane sum memory: registered read ahead, write from the accumulate stage
  always_ff @(posedge clk) begin
    lane_q_r <= lane_mem[head_px];
    if (b_valid_r) begin
      lane_mem[b_px_r] <= b_new;
    end
  end

  // accumulate, with bypass of the latest write
  always_comb begin
    b_old = (fwd_valid_r && fwd_px_r == b_px_r) ? fwd_sums_r : lane_q_r;
    for (int i = 0; i < 4; i++) begin
      b_new[i] = b_first_r ? SUM_W'(color_q_r[8*i +: 8])
                           : b_old[i] + SUM_W'(color_q_r[8*i +: 8]);
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      b_valid_r <= work_pop && (work_data.op == OP_CELL);
      c_valid_r <= b_valid_r && b_emit_r;
      if (b_valid_r) begin
        fwd_valid_r <= 1'b1;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    b_px_r      <= head_px;
    b_first_r   <= work_data.first;
    b_emit_r    <= work_data.emit;
    b_row_end_r <= work_data.row_end;
    if (b_valid_r) begin
      fwd_px_r   <= b_px_r;
      fwd_sums_r <= b_new;
    end
    c_sums_r    <= b_new;
    c_px_r      <= b_px_r;
    c_row_end_r <= b_row_end_r;
  end

  // divide each lane by oversample squared through the reciprocal
  assign recip = recip_of(os_eff);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i] = PROD_W'(c_sums_r[i]) * PROD_W'(recip);
    end
    for (int i = 0; i < 4; i++) begin
      res.pixel[8*i +: 8] = prod[i][RECIP_SHIFT +: 8];
    end
    res.pixel_column = 10'(32'(c_px_r));
    res.row_end      = c_row_end_r;
  end

  // result queue
  hcd_queue #(
    .T     (hcd_out_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (c_valid_r),
    .push_data (res),
    .full      (),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty),
    .count     (out_count)
  );

endmodule

[rtl/histogram_colormap_downsampler.sv]
// top level: colour-mapped box downsampler of histogram counts
//
//  channel  direction  handshake                 transfer payload
//  in_      input      in_push / in_full         hcd_in_t   (load or count)
//  out_     output     out_pop / out_empty       hcd_out_t  (pixel, column, row end)
//  cfg_     input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one item per cycle sustained while out_ keeps popping; a closing cell reaches
// the out_ ports through the work queue, table and sum read, accumulate and the
// result queue; the divide sits in front of the result queue.
// the colour table read port and the lane sum read port set that rate.
// reset clears position, settings, stage flags and queues; table and sums need
// no clearing pass. a stalled out_ side fills the four-deep result queue, then
// the work queue, then in_full rises.
module histogram_colormap_downsampler #(
  parameter int TABLE_DEPTH    = 4096,
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_OVERSAMPLE = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  hcd_pkg::hcd_in_t  in_data,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output hcd_pkg::hcd_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data
);
  import hcd_pkg::*;

  `include "histogram_colormap_downsampler_defines.svh"

  localparam int WORK_DEPTH = 4;

  logic [2:0]          oversample_r;
  logic [10:0]         pixel_width_r;
  logic [11:0]         table_top_r;
  logic                cfg_wr, restart;
  logic [2:0]          os_eff;
  logic [PX_MAX_W-1:0] wlast;
  logic [31:0]         wlast_full;

  logic                work_push, work_full, work_pop, work_empty;
  hcd_work_t           work_in, work_out;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index == REG_OVERSAMPLE || cfg_index == REG_PIXEL_WIDTH);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oversample_r  <= 3'd1;
      pixel_width_r <= 11'd1024;
      table_top_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_OVERSAMPLE:  oversample_r  <= cfg_data[2:0];
        REG_PIXEL_WIDTH: pixel_width_r <= cfg_data[10:0];
        REG_TABLE_TOP:   table_top_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (oversample_r == 3'd0) begin
      os_eff = 3'd1;
    end else if (32'(oversample_r) > 32'(MAX_OVERSAMPLE)) begin
      os_eff = 3'(MAX_OVERSAMPLE);
    end else begin
      os_eff = oversample_r;
    end
    if (pixel_width_r == 11'd0) begin
      wlast_full = '0;
    end else if (32'(pixel_width_r) > 32'(MAX_WIDTH)) begin
      wlast_full = 32'(MAX_WIDTH - 1);
    end else begin
      wlast_full = 32'(pixel_width_r) - 32'd1;
    end
    wlast = PX_MAX_W'(wlast_full);
  end

  hcd_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .restart   (restart),
    .os_eff    (os_eff),
    .wlast     (wlast),
    .table_top (table_top_r),
    .work_push (work_push),
    .work_data (work_in),
    .work_full (work_full)
  );

  hcd_queue #(
    .T     (hcd_work_t),
    .DEPTH (WORK_DEPTH)
  ) u_work_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (work_push),
    .push_data (work_in),
    .full      (work_full),
    .pop       (work_pop),
    .pop_data  (work_out),
    .empty     (work_empty),
    .count     ()
  );

  hcd_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MAX_OVERSAMPLE (MAX_OVERSAMPLE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work_empty (work_empty),
    .work_data  (work_out),
    .work_pop   (work_pop),
    .os_eff     (os_eff),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .out_empty  (out_empty)
  );

  // effective oversample stays within one and the maximum
  `HCD_ASSERT_NOW(a_os_range, 1'b1, os_eff != 3'd0 && 32'(os_eff) <= MAX_OVERSAMPLE, "oversample out of range")
  // last column index stays inside the lane sum memory
  `HCD_ASSERT_NOW(a_wlast_range, 1'b1, 32'(wlast) < MAX_WIDTH, "row end beyond memory")
  // an in-range oversample write takes effect on the next cycle
  `HCD_ASSERT_NEXT(a_os_write, cfg_valid && cfg_ready && cfg_index == REG_OVERSAMPLE && cfg_data[2:0] != 3'd0 && 32'(cfg_data[2:0]) <= MAX_OVERSAMPLE, os_eff == $past(cfg_data[2:0]), "oversample write lost")

endmodule

[test/histogram_colormap_downsampler_check.sv]
// checker for the colormap downsampler: watches all three channels, predicts pixels, compares
`timescale 1ns / 100ps

module histogram_colormap_downsampler_check #(
  parameter int TABLE_DEPTH    = 4096,
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_OVERSAMPLE = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  hcd_pkg::hcd_in_t  in_data,
  input  logic              out_empty,
  input  logic              out_pop,
  input  hcd_pkg::hcd_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  output int                mismatch_count,
  output int                pending_count,
  output int                pixel_count,
  output int                row_end_count
);
  import hcd_pkg::*;

  // predicted block state
  logic [31:0] color_mem [TABLE_DEPTH];
  int unsigned lane_acc [MAX_WIDTH][4];
  int unsigned cell_col;
  int unsigned sub_row;
  logic [2:0]  os_reg;
  logic [10:0] width_reg;
  logic [11:0] top_reg;

  // pixels predicted but not yet popped, oldest first
  hcd_out_t awaited_pixels [$];
  int errors;
  int pixels_seen;
  int row_ends_seen;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    pixel_count    = 0;
    row_end_count  = 0;
  end

  // register write; geometry writes restart the frame position
  function automatic void write_setting(input logic [1:0] idx, input logic [11:0] val);
    case (idx)
      REG_OVERSAMPLE: begin
        os_reg   = val[2:0];
        cell_col = 0;
        sub_row  = 0;
      end
      REG_PIXEL_WIDTH: begin
        width_reg = val[10:0];
        cell_col  = 0;
        sub_row   = 0;
      end
      REG_TABLE_TOP: top_reg = val;
      default: ;
    endcase
  endfunction

  // one histogram cell: look up, accumulate, maybe close a block
  function automatic void downsample_cell(input logic [31:0] cnt);
    int unsigned os, w, px, sx, idx, div, lane, b;
    logic [31:0] color;
    hcd_out_t    pix;
    bit          closes;
    os = (os_reg == 0) ? 1 : ((os_reg > MAX_OVERSAMPLE) ? MAX_OVERSAMPLE : os_reg);
    w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);

    // clamp to the table top and the table size
    idx = top_reg;
    if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
    if (cnt < idx) idx = cnt;
    color = color_mem[idx];

    px = cell_col / os;
    sx = cell_col % os;
    if (px >= w) px = w - 1;

    // first cell of a block overwrites the column sums
    for (lane = 0; lane < 4; lane++) begin
      b = color[8*lane +: 8];
      if (sub_row == 0 && sx == 0) lane_acc[px][lane] = b;
      else lane_acc[px][lane] += b;
    end

    closes = (sub_row == os - 1) && (sx == os - 1);
    cell_col++;
    if (cell_col >= w * os) begin
      cell_col = 0;
      sub_row++;
      if (sub_row >= os) sub_row = 0;
    end

    if (closes) begin
      div = os * os;
      for (lane = 0; lane < 4; lane++) pix.pixel[8*lane +: 8] = 8'(lane_acc[px][lane] / div);
      pix.pixel_column = px[9:0];
      pix.row_end      = (px == w - 1);
      awaited_pixels.push_back(pix);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // compare a popped pixel with the oldest prediction
  function automatic void check_pixel(input hcd_out_t got);
    hcd_out_t want;
    if (awaited_pixels.size() == 0) begin
      errors++;
      $display("%0t: pixel %h column %0d popped with none awaited",
               $time, got.pixel, got.pixel_column);
      return;
    end
    want = awaited_pixels.pop_front();
    check_field("pixel", want.pixel, got.pixel);
    check_field("pixel_column", want.pixel_column, got.pixel_column);
    check_field("row_end", want.row_end, got.row_end);
    pixels_seen++;
    if (got.row_end) row_ends_seen++;
  endfunction

  // sample every transfer at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_pixels.delete();
      cell_col      = 0;
      sub_row       = 0;
      os_reg        = 3'd1;
      width_reg     = 11'd1024;
      top_reg       = 12'd0;
      errors        = 0;
      pixels_seen   = 0;
      row_ends_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (in_push && !in_full) begin
        if (in_data.command == CMD_LOAD) begin
          if (in_data.table_index < TABLE_DEPTH)
            color_mem[in_data.table_index] = in_data.table_color;
        end else begin
          downsample_cell(in_data.count);
        end
      end
      if (out_pop && !out_empty) check_pixel(out_data);
    end
    mismatch_count <= errors;
    pending_count  <= awaited_pixels.size();
    pixel_count    <= pixels_seen;
    row_end_count  <= row_ends_seen;
  end

endmodule

[test/histogram_colormap_downsampler_test.sv]
// testbench top for the colormap downsampler: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module histogram_colormap_downsampler_test;
  import hcd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  // index with no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  hcd_in_t     in_data = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  hcd_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  int mismatch_count;
  int pending_count;
  int pixel_count;
  int row_end_count;

  // stimulus bookkeeping
  bit          color_loaded [4096];
  logic [11:0] cur_top = '0;
  int          in_idle_pct;
  int          out_idle_pct;
  int          holds_asked;
  int          holds_served;
  int          loads_sent;
  int          cells_sent;
  int          settings_used;
  int          stall_cycles;
  int          cycle_count;

  histogram_colormap_downsampler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  histogram_colormap_downsampler_check i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_data        (in_data),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .pixel_count    (pixel_count),
    .row_end_count  (row_end_count)
  );

  always #10 clk = ~clk;

  // input transfer, with an occasional gap before it
  task automatic send_item(input hcd_in_t item);
    int gap;
    if ($urandom_range(99) < in_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_load(input logic [11:0] idx, input logic [31:0] color);
    hcd_in_t item;
    item.command     = CMD_LOAD;
    item.table_index = idx;
    item.table_color = color;
    item.count       = $urandom;
    color_loaded[idx] = 1'b1;
    loads_sent++;
    send_item(item);
  endtask

  task automatic send_count(input logic [31:0] cnt);
    hcd_in_t item;
    item.command     = CMD_COUNT;
    item.table_index = 12'($urandom);
    item.table_color = $urandom;
    item.count       = cnt;
    cells_sent++;
    send_item(item);
  endtask

  // count whose lookup lands on a loaded colour entry
  function automatic logic [31:0] pick_count();
    logic [31:0] c;
    case ($urandom_range(2))
      0:       c = $urandom;
      1:       c = 32'(cur_top);
      default: c = $urandom_range(cur_top, 0);
    endcase
    if (c <= cur_top && !color_loaded[c]) c = 32'(cur_top);
    return c;
  endfunction

  // stop offering, wait for every pixel, then let loads drain
  task automatic settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TABLE_TOP) cur_top = val;
  endtask

  // full register set while idle; unused data bits carry noise
  task automatic configure(input logic [2:0] os, input logic [10:0] w, input logic [11:0] top,
                           input bit poke_spare);
    logic [8:0] noise;
    noise = 9'($urandom);
    settle();
    set_reg(REG_OVERSAMPLE, {noise, os});
    set_reg(REG_PIXEL_WIDTH, {noise[0], w});
    set_reg(REG_TABLE_TOP, top);
    if (poke_spare) set_reg(REG_SPARE, 12'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
    if (!color_loaded[top]) send_load(top, $urandom);
  endtask

  task automatic random_phase(input int n, input int load_pct);
    logic [11:0] idx;
    repeat (n) begin
      if ($urandom_range(99) < load_pct) begin
        idx = ($urandom_range(1) != 0) ? 12'($urandom_range(cur_top, 0))
                                       : 12'($urandom_range(4095, 0));
        send_load(idx, $urandom);
      end else begin
        send_count(pick_count());
      end
    end
  endtask

  // result side: random pops, plus a long hold-off when asked
  initial begin : result_drain
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (holds_served < holds_asked) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served++;
      end else begin
        out_pop <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // cycles with an item offered but refused
  always @(posedge clk)
    if (in_push && in_full) stall_cycles <= stall_cycles + 1;

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: no finish after %0d cycles", $time, CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int i;
    logic [31:0] corner [4];
    logic [2:0]  os_list [10];
    logic [10:0] width_list [10];
    logic [11:0] top_list [10];
    corner     = '{32'd0, 32'd2, 32'hFFF, 32'hFFFF_FFFF};
    os_list    = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd3, 3'd2, 3'd4};
    width_list = '{11'd3, 11'd5, 11'd2, 11'd3, 11'd1, 11'd4, 11'd7, 11'd1, 11'd0, 11'd2};
    top_list   = '{12'd15, 12'd255, 12'd4095, 12'd100, 12'd7, 12'd0, 12'd2047, 12'd31,
                   12'd4095, 12'd1};
    in_idle_pct  = 10;
    out_idle_pct = 76;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry, table top zero: every count clamps to entry zero
    send_load(12'd0, 32'h8040_20FF);
    send_load(12'hFFF, 32'hFFFF_FFFF);
    send_load(12'd2, 32'h7F80_01FE);
    send_count(32'd0);
    send_count(32'hFFFF_FFFF);

    // top raised mid-row: position carries on
    settle();
    set_reg(REG_TABLE_TOP, 12'hFFF);
    cfg_valid <= 1'b0;
    send_count(32'hFFF);
    send_count(32'd2);

    // zero oversample and zero width act as one: one pixel per cell
    settle();
    set_reg(REG_OVERSAMPLE, 12'd0);
    set_reg(REG_PIXEL_WIDTH, 12'd0);
    cfg_valid <= 1'b0;
    send_count(32'hFFFF_FFFF);
    send_count(32'd0);

    // oversample above the maximum: one 4x4 block
    settle();
    set_reg(REG_OVERSAMPLE, 12'd7);
    set_reg(REG_PIXEL_WIDTH, 12'd1);
    cfg_valid <= 1'b0;
    for (i = 0; i < 16; i++) send_count(corner[i % 4]);

    // random phases over several geometries
    for (i = 0; i < 10; i++) begin
      if (i == 4) begin
        in_idle_pct  = 76;
        out_idle_pct = 10;
      end
      if (i == 8) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      configure(os_list[i], width_list[i], top_list[i], i == 3);
      if (i == 0) holds_asked++;
      random_phase(115, 15);
    end

    settle();
    $display("sent %0d table loads and %0d cells over %0d register settings",
             loads_sent, cells_sent, settings_used);
    $display("checked %0d pixels, %0d row ends; input refused on %0d cycles",
             pixel_count, row_end_count, stall_cycles);
    if (mismatch_count == 0 && pending_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[histogram_colormap_downsampler.f]
+incdir+rtl
rtl/hcd_pkg.sv
rtl/hcd_queue.sv
rtl/hcd_front.sv
rtl/hcd_back.sv
rtl/histogram_colormap_downsampler.sv
test/histogram_colormap_downsampler_check.sv
test/histogram_colormap_downsampler_test.sv
